[rtl/core/qpl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpl_pkg: shared types and constants for the quadrature PID position loop
// Word layouts, register codes, fixed-point widths and the duty helper.
// ----------------------------------------------------------------------------
package qpl_pkg;

	// Loop constants
	localparam int COUNTS_PER_REV = 216;
	localparam int PWM_MAX        = 100;

	// Field widths
	localparam int REF_W  = 16;
	localparam int GAIN_W = 32;
	localparam int TICK_W = 16;
	localparam int POS_W  = 32;
	localparam int ERR_W  = 32;
	localparam int DUTY_W = 7;
	localparam int ACC_W  = 48;
	localparam int FRAC_W = 16;
	localparam int PROD_W = GAIN_W + ERR_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam int TOT_W  = SUM_W + 1;

	// Configuration port
	localparam int DATA_W = 32;
	localparam int ADDR_W = 5;
	localparam int IDX_W  = 3;

	localparam logic [IDX_W-1:0] REG_REFERENCE = 3'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_NOW  = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_PREV = 3'd2;
	localparam logic [IDX_W-1:0] REG_GAIN_PREV2 = 3'd3;
	localparam logic [IDX_W-1:0] REG_RUN_TICKS = 3'd4;

	localparam logic signed [REF_W-1:0]  REFERENCE_RST  = '0;
	localparam logic signed [GAIN_W-1:0] GAIN_NOW_RST   = GAIN_W'(60681);
	localparam logic signed [GAIN_W-1:0] GAIN_PREV_RST  = GAIN_W'(-91022);
	localparam logic signed [GAIN_W-1:0] GAIN_PREV2_RST = GAIN_W'(30341);
	localparam logic [TICK_W-1:0]        RUN_TICKS_RST  = TICK_W'(500);

	// Request codes
	localparam logic [1:0] REQ_EDGE_A = 2'd0;
	localparam logic [1:0] REQ_EDGE_B = 2'd1;
	localparam logic [1:0] REQ_TICK   = 2'd2;

	typedef struct packed {
		logic [1:0] req_type;
		logic       line_a;
		logic       line_b;
	} in_word_t;

	typedef struct packed {
		logic signed [POS_W-1:0] position;
		logic [DUTY_W-1:0]       drive_fwd;
		logic [DUTY_W-1:0]       drive_rev;
		logic signed [ERR_W-1:0] error_out;
		logic                    done_res;
	} out_word_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] gain_now;
		logic signed [GAIN_W-1:0] gain_prev;
		logic signed [GAIN_W-1:0] gain_prev2;
	} gains_t;

	// State after the item, carried beside the arithmetic
	typedef struct packed {
		logic signed [POS_W-1:0] position;
		logic signed [ERR_W-1:0] error_out;
		logic                    done;
	} tag_t;

	typedef struct packed {
		logic signed [ERR_W-1:0] err_a;
		logic signed [ERR_W-1:0] err_b;
		logic signed [ERR_W-1:0] err_c;
		tag_t                    tag;
	} enc_stage_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] acc;
		tag_t                    tag;
	} acc_stage_t;

	// Integer part of a Q.16 value, floored at zero and clamped to PWM_MAX
	function automatic logic [DUTY_W-1:0] duty_of(input logic signed [ACC_W:0] v);
		logic [ACC_W-FRAC_W:0] whole;
		whole = v[ACC_W:FRAC_W];
		if (v <= 0)
			return '0;
		else if (whole > (ACC_W-FRAC_W+1)'(PWM_MAX))
			return DUTY_W'(PWM_MAX);
		else
			return whole[DUTY_W-1:0];
	endfunction

endpackage

[rtl/core/qpl_encoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpl_encoder: quadrature count, error history and tick bookkeeping
// Updates the position count on edges and forms the saturated error on ticks.
// ----------------------------------------------------------------------------
module qpl_encoder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  logic                                accept,
	input  qpl_pkg::in_word_t                   word,
	input  logic signed [qpl_pkg::REF_W-1:0]    reference_turns,
	input  logic [qpl_pkg::TICK_W-1:0]          run_ticks,
	output qpl_pkg::enc_stage_t                 enc_s1,
	output logic                                upd_s1
);
	import qpl_pkg::*;

	localparam int EXT_W = POS_W + 2;
	localparam logic signed [EXT_W-1:0] CPR_EXT = EXT_W'(COUNTS_PER_REV);
	localparam logic signed [EXT_W-1:0] ERR_HI  = EXT_W'((64'sd1 <<< (ERR_W-1)) - 1);
	localparam logic signed [EXT_W-1:0] ERR_LO  = EXT_W'(-(64'sd1 <<< (ERR_W-1)));

	logic [POS_W-1:0]        count_q, count_n;
	logic signed [ERR_W-1:0] err_last_q, err_last_n;
	logic signed [ERR_W-1:0] err_before_q, err_before_n;
	logic [TICK_W-1:0]       tick_q, tick_n;
	logic                    done_q, done_n;
	logic                    upd_n;
	logic signed [EXT_W-1:0] err_wide;
	logic signed [ERR_W-1:0] err_sat;

	always_comb begin
		err_wide = EXT_W'(reference_turns) * CPR_EXT - EXT_W'($signed(count_q));
		if (err_wide > ERR_HI)
			err_sat = ERR_HI[ERR_W-1:0];
		else if (err_wide < ERR_LO)
			err_sat = ERR_LO[ERR_W-1:0];
		else
			err_sat = err_wide[ERR_W-1:0];
	end

	always_comb begin
		count_n      = count_q;
		err_last_n   = err_last_q;
		err_before_n = err_before_q;
		tick_n       = tick_q;
		done_n       = done_q;
		upd_n        = 1'b0;
		if (accept) begin
			case (word.req_type)
				REQ_EDGE_A: begin
					count_n = (word.line_a != word.line_b) ? count_q + POS_W'(1)
						: count_q - POS_W'(1);
				end
				REQ_EDGE_B: begin
					count_n = (word.line_a == word.line_b) ? count_q + POS_W'(1)
						: count_q - POS_W'(1);
				end
				REQ_TICK: begin
					if (!done_q) begin
						upd_n        = 1'b1;
						err_before_n = err_last_q;
						err_last_n   = err_sat;
						tick_n       = (tick_q == '1) ? tick_q : tick_q + TICK_W'(1);
						done_n       = (tick_n >= run_ticks);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			err_last_q   <= '0;
			err_before_q <= '0;
			tick_q       <= '0;
			done_q       <= 1'b0;
			upd_s1       <= 1'b0;
		end else begin
			count_q      <= count_n;
			err_last_q   <= err_last_n;
			err_before_q <= err_before_n;
			tick_q       <= tick_n;
			done_q       <= done_n;
			if (adv)
				upd_s1 <= upd_n;
		end
	end

	// Multiplier operands: new error and the history before the shift
	always_ff @(posedge clk) begin
		if (adv) begin
			enc_s1.err_a         <= err_sat;
			enc_s1.err_b         <= err_last_q;
			enc_s1.err_c         <= err_before_q;
			enc_s1.tag.position  <= $signed(count_n);
			enc_s1.tag.error_out <= err_last_n;
			enc_s1.tag.done      <= done_n;
		end
	end

endmodule

[rtl/core/qpl_accum.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpl_accum: PID products and saturating drive accumulator
// Three parallel products, a registered sum, then the 48-bit Q32.16 update.
// ----------------------------------------------------------------------------
module qpl_accum (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  qpl_pkg::enc_stage_t   enc_s1,
	input  logic                  upd_s1,
	input  qpl_pkg::gains_t       gains,
	output qpl_pkg::acc_stage_t   acc_s4
);
	import qpl_pkg::*;

	localparam logic signed [TOT_W-1:0] ACC_HI = (TOT_W'(1) <<< (ACC_W-1)) - TOT_W'(1);
	localparam logic signed [TOT_W-1:0] ACC_LO = -(TOT_W'(1) <<< (ACC_W-1));

	logic signed [PROD_W-1:0] p_now_s2, p_prev_s2, p_prev2_s2;
	tag_t                     tag_s2, tag_s3;
	logic                     upd_s2, upd_s3;
	logic signed [SUM_W-1:0]  sum_s3;
	logic signed [ACC_W-1:0]  acc_q, acc_n;
	logic signed [TOT_W-1:0]  total;

	always_comb begin
		total = TOT_W'(sum_s3) + TOT_W'(acc_q);
		if (!upd_s3)
			acc_n = acc_q;
		else if (total > ACC_HI)
			acc_n = ACC_HI[ACC_W-1:0];
		else if (total < ACC_LO)
			acc_n = ACC_LO[ACC_W-1:0];
		else
			acc_n = total[ACC_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_s2 <= 1'b0;
			upd_s3 <= 1'b0;
			acc_q  <= '0;
		end else if (adv) begin
			upd_s2 <= upd_s1;
			upd_s3 <= upd_s2;
			acc_q  <= acc_n;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_now_s2   <= gains.gain_now   * enc_s1.err_a;
			p_prev_s2  <= gains.gain_prev  * enc_s1.err_b;
			p_prev2_s2 <= gains.gain_prev2 * enc_s1.err_c;
			tag_s2     <= enc_s1.tag;
			sum_s3     <= SUM_W'(p_now_s2) + SUM_W'(p_prev_s2) + SUM_W'(p_prev2_s2);
			tag_s3     <= tag_s2;
			acc_s4.acc <= acc_n;
			acc_s4.tag <= tag_s3;
		end
	end

endmodule

[rtl/core/quadrature_pid_position_loop.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_pid_position_loop: encoder counter with incremental PID drive
// Counts quadrature edges and runs a velocity-form PID on sample ticks.
// ----------------------------------------------------------------------------
//
//   channel   handshake                  word
//   -------   -------------------------  ------------------------------------
//   request   req_valid / req_stall      req_word  (req_type, line_a, line_b)
//   result    res_valid / res_stall      res_word  (position, drive_fwd,
//                                                   drive_rev, error_out, done_res)
//   config    psel/penable/pwrite/pready paddr, pwdata, prdata (APB, 4-byte regs)
//
// One word per cycle enters while the pipe advances; each yields one result word
// after the count, products, product sum, accumulator and duty/output stages.
// The pipeline advances as one unit; it holds only while a result waits in
// the output register and res_stall is high, and then req_stall is raised.
// arst_n clears the count, error history, tick count, done, accumulator and
// all stage valid bits; configuration registers return to their defaults.
//
module quadrature_pid_position_loop (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  qpl_pkg::in_word_t              req_word,
	output logic                           res_valid,
	input  logic                           res_stall,
	output qpl_pkg::out_word_t             res_word,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [qpl_pkg::ADDR_W-1:0]     paddr,
	input  logic [qpl_pkg::DATA_W-1:0]     pwdata,
	output logic [qpl_pkg::DATA_W-1:0]     prdata,
	output logic                           pready
);
	import qpl_pkg::*;

	// Configuration registers
	logic signed [REF_W-1:0]  reference_q;
	gains_t                   gains_q;
	logic [TICK_W-1:0]        run_ticks_q;
	logic [IDX_W-1:0]         reg_idx;
	logic                     cfg_write;

	// Pipeline control
	logic                     adv;
	logic                     accept;
	logic                     valid_s1, valid_s2, valid_s3, valid_s4;
	logic                     res_valid_q;
	out_word_t                res_word_q;

	enc_stage_t               enc_s1;
	logic                     upd_s1;
	acc_stage_t               acc_s4;

	// Duty selection from the accumulator snapshot
	logic signed [ACC_W:0]    acc_pos, acc_neg;
	logic                     err_positive;
	logic [DUTY_W-1:0]        fwd_duty, rev_duty;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[ADDR_W-1:ADDR_W-IDX_W];
	assign cfg_write = psel && penable && pwrite && pready;

	// --- configuration port --------------------------------------------------

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reference_q        <= REFERENCE_RST;
			gains_q.gain_now   <= GAIN_NOW_RST;
			gains_q.gain_prev  <= GAIN_PREV_RST;
			gains_q.gain_prev2 <= GAIN_PREV2_RST;
			run_ticks_q        <= RUN_TICKS_RST;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_REFERENCE:  reference_q        <= pwdata[REF_W-1:0];
				REG_GAIN_NOW:   gains_q.gain_now   <= pwdata[GAIN_W-1:0];
				REG_GAIN_PREV:  gains_q.gain_prev  <= pwdata[GAIN_W-1:0];
				REG_GAIN_PREV2: gains_q.gain_prev2 <= pwdata[GAIN_W-1:0];
				REG_RUN_TICKS:  run_ticks_q        <= pwdata[TICK_W-1:0];
				default: begin
					// drop writes past the last register
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_REFERENCE:  prdata = DATA_W'(reference_q);
			REG_GAIN_NOW:   prdata = DATA_W'(gains_q.gain_now);
			REG_GAIN_PREV:  prdata = DATA_W'(gains_q.gain_prev);
			REG_GAIN_PREV2: prdata = DATA_W'(gains_q.gain_prev2);
			REG_RUN_TICKS:  prdata = DATA_W'(run_ticks_q);
			default:        prdata = '0;
		endcase
	end

	// --- pipeline control ----------------------------------------------------

	// Advance whenever the output register is empty or being taken
	assign adv       = !res_valid_q || !res_stall;
	assign req_stall = !adv;
	assign accept    = req_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= accept;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			res_valid_q <= valid_s4;
		end
	end

	// --- datapath ------------------------------------------------------------

	// Stage 1: count update, error formation, tick and done bookkeeping
	qpl_encoder u_encoder (
		.clk             (clk),
		.arst_n          (arst_n),
		.adv             (adv),
		.accept          (accept),
		.word            (req_word),
		.reference_turns (reference_q),
		.run_ticks       (run_ticks_q),
		.enc_s1          (enc_s1),
		.upd_s1          (upd_s1)
	);

	// Stages 2-4: products, their sum, accumulator update
	qpl_accum u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.enc_s1  (enc_s1),
		.upd_s1  (upd_s1),
		.gains   (gains_q),
		.acc_s4  (acc_s4)
	);

	// Output stage: error sign picks the direction, done forces both to zero.
	// Negate in one extra bit so the most negative accumulator stays positive.
	always_comb begin
		acc_pos      = (ACC_W+1)'(acc_s4.acc);
		acc_neg      = -acc_pos;
		err_positive = (acc_s4.tag.error_out > 0);
		fwd_duty     = (!acc_s4.tag.done && err_positive)  ? duty_of(acc_pos) : '0;
		rev_duty     = (!acc_s4.tag.done && !err_positive) ? duty_of(acc_neg) : '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_word_q.position  <= acc_s4.tag.position;
			res_word_q.drive_fwd <= fwd_duty;
			res_word_q.drive_rev <= rev_duty;
			res_word_q.error_out <= acc_s4.tag.error_out;
			res_word_q.done_res  <= acc_s4.tag.done;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

	// --- assertions ----------------------------------------------------------

	// Only one direction may be driven at a time
	a_one_direction: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_word.drive_fwd == '0 || res_word.drive_rev == '0))
		else $error("both drive directions nonzero");

	// A finished loop drives nothing
	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_word.done_res) |->
		(res_word.drive_fwd == '0 && res_word.drive_rev == '0))
		else $error("drive nonzero after done");

	// Duty never passes the clamp
	a_duty_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_word.drive_fwd <= DUTY_W'(PWM_MAX) &&
		res_word.drive_rev <= DUTY_W'(PWM_MAX)))
		else $error("duty above clamp");

	// A word in the last stage reaches the output when the pipe advances
	a_stage_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && adv) |=> res_valid)
		else $error("result word lost between last stage and output");

endmodule
